/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file lmb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("level meter check failed");

// Next-cycle implication, held off during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("level meter check failed");

`endif

/* rtl/core/lmb_pkg.sv */
`timescale 1ns / 1ps

package lmb_pkg;

    localparam int VALUE_W = 16;
    localparam int COEFF_W = 16;
    localparam int FALL_W  = 12;
    localparam int HOLD_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W:0]   ONE_DB  = 17'sd16;

    localparam logic [1:0] MODE_READING = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [1:0] COLOUR_QUIET   = 2'd0;
    localparam logic [1:0] COLOUR_IN_BAND = 2'd1;
    localparam logic [1:0] COLOUR_HOT     = 2'd2;
    localparam logic [1:0] COLOUR_CLIP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 3'd5;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] reading_level;
        logic signed [VALUE_W-1:0] reading_peak;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] shown_level;
        logic signed [VALUE_W-1:0] shown_peak;
        logic [1:0]                colour_class;
        logic                      data_valid;
    } out_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] scale_max;
        logic signed [VALUE_W-1:0] band_low;
        logic signed [VALUE_W-1:0] band_high;
        logic [COEFF_W-1:0]        decay_factor;
        logic [FALL_W-1:0]         fall_step;
        logic [HOLD_W-1:0]         hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] bar_level;
        logic signed [VALUE_W-1:0] peak_mark;
        logic signed [VALUE_W-1:0] raw_level;
        logic signed [VALUE_W-1:0] raw_peak;
        logic [HOLD_W-1:0]         hold_left;
        logic                      have_reading;
    } state_t;

endpackage

/* rtl/core/lmb_step.sv */
`timescale 1ns / 1ps

module lmb_step
(
    input  lmb_pkg::cfg_t     cfg,
    input  lmb_pkg::state_t   cur,
    input  lmb_pkg::in_item_t item,
    output lmb_pkg::state_t   nxt,
    output lmb_pkg::out_item_t result
);

    logic signed [lmb_pkg::VALUE_W-1:0]   peak_in;
    logic signed [lmb_pkg::VALUE_W:0]     diff;
    logic [2*lmb_pkg::COEFF_W-1:0]        prod;
    logic [lmb_pkg::COEFF_W-1:0]          kept;
    logic signed [lmb_pkg::VALUE_W:0]     decayed;
    logic signed [lmb_pkg::VALUE_W-1:0]   tick_bar;
    logic signed [lmb_pkg::VALUE_W+1:0]   fallen;
    logic signed [lmb_pkg::VALUE_W+1:0]   fall_floor;
    logic signed [lmb_pkg::VALUE_W-1:0]   fall_sat;
    logic signed [lmb_pkg::VALUE_W:0]     clip_level;

    // bar decay: raw + floor((bar - raw) * k / 2^16)
    assign diff    = $signed({cur.bar_level[lmb_pkg::VALUE_W-1], cur.bar_level})
                   - $signed({cur.raw_level[lmb_pkg::VALUE_W-1], cur.raw_level});
    assign prod    = diff[lmb_pkg::COEFF_W-1:0] * cfg.decay_factor;
    assign kept    = prod[2*lmb_pkg::COEFF_W-1:lmb_pkg::COEFF_W];
    assign decayed = $signed({cur.raw_level[lmb_pkg::VALUE_W-1], cur.raw_level})
                   + $signed({1'b0, kept});
    assign tick_bar = (cur.raw_level >= cur.bar_level) ? cur.raw_level
                                                       : decayed[lmb_pkg::VALUE_W-1:0];

    // linear peak fall, floored at the minimum and then at the bar
    assign fallen     = $signed({{2{cur.peak_mark[lmb_pkg::VALUE_W-1]}}, cur.peak_mark})
                      - $signed({6'd0, cfg.fall_step});
    assign fall_floor = $signed({{2{lmb_pkg::VAL_MIN[lmb_pkg::VALUE_W-1]}}, lmb_pkg::VAL_MIN});
    assign fall_sat   = (fallen < fall_floor) ? lmb_pkg::VAL_MIN
                                              : fallen[lmb_pkg::VALUE_W-1:0];

    assign peak_in = (item.reading_peak > item.reading_level) ? item.reading_peak
                                                              : item.reading_level;

    always_comb
    begin
        nxt = cur;
        case (item.mode)
            lmb_pkg::MODE_READING:
            begin
                nxt.raw_level = item.reading_level;
                nxt.raw_peak  = peak_in;
                if (!cur.have_reading)
                begin
                    nxt.bar_level    = item.reading_level;
                    nxt.peak_mark    = peak_in;
                    nxt.hold_left    = cfg.hold_ticks;
                    nxt.have_reading = 1'b1;
                end
            end
            lmb_pkg::MODE_TICK:
            begin
                if (cur.have_reading)
                begin
                    nxt.bar_level = tick_bar;
                    if (cur.raw_peak >= cur.peak_mark)
                    begin
                        nxt.peak_mark = cur.raw_peak;
                        nxt.hold_left = cfg.hold_ticks;
                    end
                    else if (cur.hold_left != '0)
                    begin
                        nxt.hold_left = cur.hold_left - 1'b1;
                    end
                    else
                    begin
                        nxt.peak_mark = (fall_sat < tick_bar) ? tick_bar : fall_sat;
                    end
                end
            end
            lmb_pkg::MODE_CLEAR:
            begin
                nxt.bar_level    = lmb_pkg::VAL_MIN;
                nxt.peak_mark    = lmb_pkg::VAL_MIN;
                nxt.raw_level    = lmb_pkg::VAL_MIN;
                nxt.raw_peak     = lmb_pkg::VAL_MIN;
                nxt.hold_left    = '0;
                nxt.have_reading = 1'b0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign clip_level = $signed({cfg.scale_max[lmb_pkg::VALUE_W-1], cfg.scale_max})
                      - lmb_pkg::ONE_DB;

    always_comb
    begin
        result.shown_level = nxt.bar_level;
        result.shown_peak  = nxt.peak_mark;
        result.data_valid  = nxt.have_reading;
        if (!nxt.have_reading)
            result.colour_class = lmb_pkg::COLOUR_QUIET;
        else if ($signed({nxt.bar_level[lmb_pkg::VALUE_W-1], nxt.bar_level}) >= clip_level)
            result.colour_class = lmb_pkg::COLOUR_CLIP;
        else if (nxt.bar_level > cfg.band_high)
            result.colour_class = lmb_pkg::COLOUR_HOT;
        else if (nxt.bar_level >= cfg.band_low)
            result.colour_class = lmb_pkg::COLOUR_IN_BAND;
        else
            result.colour_class = lmb_pkg::COLOUR_QUIET;
    end

endmodule

/* rtl/core/level_meter_ballistics_top.sv */
`timescale 1ns / 1ps

// Level meter ballistics, values in 1/16 dB.
// Input channel item/item_valid/item_stall: one transfer is a reading, a tick
// of the repaint clock, or a clear. Each input transfer yields exactly one
// result transfer on result/result_valid/result_stall, in order.
// result_valid rises once the item has passed the input register and then
// the update logic into the result register; a stalled receiver can hold
// the item in the input register on the way.
// Throughput: one item per cycle while result_stall is low; the bar/peak
// update is a single pass with one 16x16 multiply between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, after which item_stall rises.
// Reset clears both stages, sets bar, peak and raw values to the minimum,
// clears the hold count and the data flag, and loads the default settings.
// Settings are written through cfg_we/cfg_index/cfg_data while no item is
// in flight; indexes beyond the register list are ignored.

module level_meter_ballistics_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  lmb_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lmb_pkg::out_item_t                  result,
    input  logic                                cfg_we,
    input  logic [lmb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lmb_pkg::VALUE_W-1:0]         cfg_data
);

    lmb_pkg::cfg_t      cfg_reg;
    lmb_pkg::cfg_t      cfg_next;
    lmb_pkg::state_t    state_reg;
    lmb_pkg::state_t    state_next;
    lmb_pkg::state_t    step_state;
    lmb_pkg::in_item_t  in_item_reg;
    lmb_pkg::out_item_t out_item_reg;
    lmb_pkg::out_item_t step_result;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               accept;
    logic               advance;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && out_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    lmb_step u_step
    (
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .item   (in_item_reg),
        .nxt    (step_state),
        .result (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;

        state_next = advance ? step_state : state_reg;

        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lmb_pkg::CFG_SCALE_MAX:    cfg_next.scale_max    = cfg_data;
                lmb_pkg::CFG_BAND_LOW:     cfg_next.band_low     = cfg_data;
                lmb_pkg::CFG_BAND_HIGH:    cfg_next.band_high    = cfg_data;
                lmb_pkg::CFG_DECAY_FACTOR: cfg_next.decay_factor = cfg_data;
                lmb_pkg::CFG_FALL_STEP:
                    cfg_next.fall_step  = cfg_data[lmb_pkg::FALL_W-1:0];
                lmb_pkg::CFG_HOLD_TICKS:
                    cfg_next.hold_ticks = cfg_data[lmb_pkg::HOLD_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            state_reg.bar_level    <= lmb_pkg::VAL_MIN;
            state_reg.peak_mark    <= lmb_pkg::VAL_MIN;
            state_reg.raw_level    <= lmb_pkg::VAL_MIN;
            state_reg.raw_peak     <= lmb_pkg::VAL_MIN;
            state_reg.hold_left    <= '0;
            state_reg.have_reading <= 1'b0;
            cfg_reg.scale_max      <= 16'sd0;
            cfg_reg.band_low       <= -16'sd320;
            cfg_reg.band_high      <= -16'sd96;
            cfg_reg.decay_factor   <= 16'd58708;
            cfg_reg.fall_step      <= 12'd11;
            cfg_reg.hold_ticks     <= 8'd45;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= item;
        if (advance)
            out_item_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

/* rtl/core/lmb_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmb_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input lmb_pkg::out_item_t result
);

    // result holds while the receiver stalls
    `CHK_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // input side only backs up behind a stalled, full result stage
    `CHK_IMPLY(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall)

    // no data since clear: everything at the minimum, quiet colour
    `CHK_IMPLY(a_no_data, clk, rst_n, result_valid && !result.data_valid, (result.shown_level == lmb_pkg::VAL_MIN) && (result.shown_peak == lmb_pkg::VAL_MIN) && (result.colour_class == lmb_pkg::COLOUR_QUIET))

    // peak mark never sits below the bar
    `CHK_IMPLY(a_peak_over_bar, clk, rst_n, result_valid && result.data_valid, result.shown_peak >= result.shown_level)

endmodule

bind level_meter_ballistics_top lmb_checker u_lmb_checker (.*);
